### hw/rtl/sfd_pkg.sv
// Shared constants, types and helpers of the serial frame decoder.
`default_nettype none

package sfd_pkg;

  localparam int unsigned FRAME_LENGTH_DEF = 25;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned VAL_W      = 11;
  localparam int unsigned RAW_W      = 11;
  localparam int unsigned ACC_W      = RAW_W + BYTE_W - 1;
  localparam int unsigned ACC_CW     = $clog2(ACC_W + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = VAL_W;

  localparam int unsigned ANALOG_CH   = 16;
  localparam int unsigned LAST_CH     = 17;
  localparam int unsigned FAILSAFE_BIT = 3;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'h0F;
  localparam logic [VAL_W-1:0]  OFFSET_RESET = 11'd976;
  localparam logic [VAL_W-1:0]  VAL_MAX      = 11'h7FF;
  localparam logic [VAL_W-1:0]  DIG_HIGH     = 11'd2000;
  localparam logic [VAL_W-1:0]  DIG_LOW      = 11'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_BYTE    = 1'b0,
    REG_VALUE_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FLAG = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DIG  = 4'b1000
  } state_e;

  // halve the raw field, add the offset, saturate
  function automatic logic [VAL_W-1:0] scale_value(input logic [RAW_W-1:0] raw,
                                                   input logic [VAL_W-1:0] offset);
    logic [VAL_W:0] sum;
    sum = {2'b00, raw[RAW_W-1:1]} + {1'b0, offset};
    return sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbus_frame_decoder_unit.sv
// Serial frame decoder: collects a frame, then streams 18 channel values.
// Bytes that do not complete a frame leave the decoder ready for the next byte.
// The completing byte starts a decode pass through the frame RAM: the flag byte is read,
// data bytes are shifted into an accumulator, a channel is emitted whenever 11 bits are
// held and the two digital channels follow; emits stall while the output register is full.
// Reset: frame position zero, configuration registers to defaults, output invalid; the frame RAM is not cleared.
`default_nettype none

module sbus_frame_decoder_unit
  import sfd_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,   // [7:0] rx_byte
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [15:0]           m_axis_tdata_o,   // [4:0] channel_index, [15:5] channel_value
  output logic                       m_axis_tuser_o,   // [0] failsafe_flag
  output logic                       m_axis_tlast_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STORE_DEPTH = FRAME_LENGTH - 1;
  localparam int unsigned PW = $clog2(FRAME_LENGTH);
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] FLAG_ADDR = AW'(FRAME_LENGTH - 2);
  localparam logic [AW-1:0] LAST_DATA_ADDR = AW'(FRAME_LENGTH - 3);

  logic [BYTE_W-1:0] sync_q;
  logic [VAL_W-1:0]  offset_q;

  state_e            state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic              have_q, have_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_CW-1:0] cnt_q, cnt_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [1:0]        dig_q, dig_d;
  logic              fs_q, fs_d;

  logic              out_valid_q, out_valid_d;
  logic [CH_W-1:0]   out_idx_q, out_idx_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;
  logic              out_fs_q, out_fs_d;
  logic              out_last_q, out_last_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              in_fire, slot_free, emit;
  logic [VAL_W-1:0]  emit_val;

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_val_q, out_idx_q};
  assign m_axis_tuser_o  = out_fs_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    rd_addr_d = rd_addr_q;
    have_d    = have_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    dig_d     = dig_q;
    fs_d      = fs_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_addr_q;
    emit      = 1'b0;
    emit_val  = scale_value(acc_q[RAW_W-1:0], offset_q);

    case (state_q)
      ST_IDLE: begin
        if (in_fire && !(pos_q == '0 && s_axis_tdata_i != sync_q)) begin
          if (pos_q < PW'(STORE_DEPTH)) begin
            ram_we = 1'b1;
            pos_d  = pos_q + PW'(1);
          end else begin
            pos_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = FLAG_ADDR;
            state_d   = ST_FLAG;
          end
        end
      end
      ST_FLAG: begin
        dig_d     = ram_rdata[1:0];
        fs_d      = ram_rdata[FAILSAFE_BIT];
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
        rd_addr_d = AW'(2);
        have_d    = 1'b1;
        acc_d     = '0;
        cnt_d     = '0;
        ch_d      = '0;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (ch_q == CH_W'(ANALOG_CH)) begin
          state_d = ST_DIG;
        end else if (cnt_q >= ACC_CW'(RAW_W)) begin
          if (slot_free) begin
            emit  = 1'b1;
            acc_d = acc_q >> RAW_W;
            cnt_d = cnt_q - ACC_CW'(RAW_W);
            ch_d  = ch_q + CH_W'(1);
          end
        end else if (have_q) begin
          acc_d  = acc_q | (ACC_W'(ram_rdata) << cnt_q);
          cnt_d  = cnt_q + ACC_CW'(BYTE_W);
          have_d = 1'b0;
          if (rd_addr_q <= LAST_DATA_ADDR) begin
            ram_re    = 1'b1;
            have_d    = 1'b1;
            rd_addr_d = rd_addr_q + AW'(1);
          end
        end
      end
      ST_DIG: begin
        emit_val = (ch_q == CH_W'(LAST_CH) ? dig_q[1] : dig_q[0]) ? DIG_HIGH : DIG_LOW;
        if (slot_free) begin
          emit = 1'b1;
          ch_d = ch_q + CH_W'(1);
          if (ch_q == CH_W'(LAST_CH)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_fs_d    = out_fs_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_idx_d   = ch_q;
      out_val_d   = emit_val;
      out_fs_d    = fs_q;
      out_last_d  = (ch_q == CH_W'(LAST_CH));
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= SYNC_RESET;
      offset_q    <= OFFSET_RESET;
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SYNC_BYTE:    sync_q   <= cfg_data_i[BYTE_W-1:0];
          REG_VALUE_OFFSET: offset_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      pos_q       <= pos_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    ch_q       <= ch_d;
    dig_q      <= dig_d;
    fs_q       <= fs_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_fs_q   <= out_fs_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire
